>>> hdl/pes_pkg.sv
// ----------------------------------------------------------------------------
// pes_pkg
// Shared types and constants for the path edge setup block.
// ----------------------------------------------------------------------------
`default_nettype none

package pes_pkg;

  localparam int unsigned EDGE_CAPACITY_DEF = 2048;

  localparam int unsigned COORD_W  = 24;
  localparam int unsigned ROW_W    = 23;
  localparam int unsigned OUT_ROW_W = 20;
  localparam int unsigned STEP_W   = 25;
  localparam int unsigned INDEX_W  = 11;
  localparam int unsigned SCALE_W  = 3;
  localparam int unsigned LIMIT_W  = 12;
  localparam int unsigned CFG_W    = 12;

  localparam logic [1:0] OP_MOVE  = 2'd0;
  localparam logic [1:0] OP_LINE  = 2'd1;
  localparam logic [1:0] OP_QUAD  = 2'd2;
  localparam logic [1:0] OP_CLOSE = 2'd3;

  localparam logic CFG_ROW_SCALE  = 1'b0;
  localparam logic CFG_EDGE_LIMIT = 1'b1;

  localparam logic [SCALE_W-1:0] ROW_SCALE_RST  = 3'd1;
  localparam logic [LIMIT_W-1:0] EDGE_LIMIT_RST = 12'd2048;

  typedef struct packed {
    logic capture;
    logic eval;
    logic rows;
    logic order;
    logic div_start;
    logic emit;
  } pes_cmd_t;

  typedef struct packed {
    logic edge_go;
    logic flat;
    logic div_done;
    logic out_free;
  } pes_stat_t;

endpackage

`default_nettype wire

>>> hdl/pes_div.sv
// ----------------------------------------------------------------------------
// pes_div
// Serial restoring divider, unsigned, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pes_div #(
  parameter int unsigned N_W = 24,
  parameter int unsigned D_W = 23
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [N_W-1:0] dividend,
  input  wire logic [D_W-1:0] divisor,
  output logic                done,
  output logic [N_W-1:0]      quotient
);

  localparam int unsigned CNT_W = $clog2(N_W + 1);

  logic [D_W-1:0]   rem_r, rem_nxt;
  logic [N_W-1:0]   quo_r, quo_nxt;
  logic [D_W-1:0]   den_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [D_W:0]     rem_sh;
  logic [D_W+1:0]   trial;

  assign rem_sh = {rem_r, quo_r[N_W-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = CNT_W'(N_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[D_W+1]) begin
        rem_nxt = trial[D_W-1:0];
        quo_nxt = {quo_r[N_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[D_W-1:0];
        quo_nxt = {quo_r[N_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      den_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

>>> hdl/pes_dp.sv
// ----------------------------------------------------------------------------
// pes_dp
// Datapath: path state, config registers, row mapping, edge ordering,
// divider and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pes_dp
  import pes_pkg::*;
#(
  parameter int unsigned EDGE_CAPACITY = EDGE_CAPACITY_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire pes_cmd_t                    cmd,
  output pes_stat_t                        stat,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_addr,
  input  wire logic [CFG_W-1:0]            cfg_wdata,
  input  wire logic [1:0]                  in_opcode,
  input  wire logic signed [COORD_W-1:0]   in_point_x,
  input  wire logic signed [COORD_W-1:0]   in_point_y,
  input  wire logic                        in_path_start,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic signed [OUT_ROW_W-1:0]      out_row_top,
  output logic signed [OUT_ROW_W-1:0]      out_row_bottom,
  output logic                             out_winding_up,
  output logic signed [COORD_W-1:0]        out_x_start,
  output logic signed [STEP_W-1:0]         out_x_step,
  output logic [INDEX_W-1:0]               out_edge_index
);

  localparam int unsigned CNT_W = $clog2(EDGE_CAPACITY + 1);
  localparam int unsigned LIM_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam int unsigned MAG_W = COORD_W;

  function automatic logic signed [ROW_W-1:0] to_row(
    input logic signed [COORD_W-1:0] y,
    input logic [SCALE_W-1:0]        s
  );
    logic signed [COORD_W-7:0] whole;
    logic signed [COORD_W-3:0] prod;
    logic [8:0]                fp;
    whole  = y[COORD_W-1:6];
    prod   = (COORD_W-2)'(whole) * (COORD_W-2)'($signed({1'b0, s}));
    fp     = 9'(y[5:0]) * 9'(s);
    to_row = {{(ROW_W-COORD_W+2){prod[COORD_W-3]}}, prod}
             + ROW_W'({1'b0, fp[8:6]});
  endfunction

  // config
  logic [SCALE_W-1:0] row_scale_r;
  logic [LIMIT_W-1:0] edge_limit_r;

  // path state
  logic signed [COORD_W-1:0] cur_x_r, cur_y_r, sub_x_r, sub_y_r;
  logic [CNT_W-1:0]          cnt_r;

  // captured command
  logic [1:0]                op_r;
  logic signed [COORD_W-1:0] px_r, py_r;
  logic                      ps_r;

  // edge work registers
  logic signed [COORD_W-1:0] x0_r, y0_r, x1_r, y1_r;
  logic signed [ROW_W-1:0]   r0_r, r1_r;
  logic signed [ROW_W-1:0]   top_r, bot_r;
  logic                      up_r;
  logic signed [COORD_W-1:0] xs_r;
  logic                      neg_r;
  logic [MAG_W-1:0]          mag_r;
  logic [ROW_W-1:0]          span_r;

  // output register
  logic                        out_valid_r;
  logic signed [OUT_ROW_W-1:0] top_o_r, bot_o_r;
  logic                        up_o_r;
  logic signed [COORD_W-1:0]   xs_o_r;
  logic signed [STEP_W-1:0]    step_o_r;
  logic [INDEX_W-1:0]          idx_o_r;

  // eval logic
  logic signed [COORD_W-1:0] cx_eff, cy_eff, sx_eff, sy_eff;
  logic [CNT_W-1:0]          cnt_eff;
  logic [LIM_W-1:0]          lim_ext, cap_ext, lim_eff;
  logic                      limited;
  logic signed [COORD_W-1:0] tx, ty;

  assign cx_eff  = ps_r ? '0 : cur_x_r;
  assign cy_eff  = ps_r ? '0 : cur_y_r;
  assign sx_eff  = ps_r ? '0 : sub_x_r;
  assign sy_eff  = ps_r ? '0 : sub_y_r;
  assign cnt_eff = ps_r ? '0 : cnt_r;
  assign lim_ext = LIM_W'(edge_limit_r);
  assign cap_ext = LIM_W'(EDGE_CAPACITY);
  assign lim_eff = (lim_ext > cap_ext) ? cap_ext : lim_ext;
  assign limited = LIM_W'(cnt_eff) >= lim_eff;
  assign tx      = (op_r == OP_LINE) ? px_r : sx_eff;
  assign ty      = (op_r == OP_LINE) ? py_r : sy_eff;

  // order logic
  logic                      down;
  logic signed [ROW_W-1:0]   top_c, bot_c;
  logic signed [STEP_W-1:0]  diff_c, negd_c;

  assign down   = r0_r < r1_r;
  assign top_c  = down ? r0_r : r1_r;
  assign bot_c  = down ? r1_r : r0_r;
  assign diff_c = down ? ({x1_r[COORD_W-1], x1_r} - {x0_r[COORD_W-1], x0_r})
                       : ({x0_r[COORD_W-1], x0_r} - {x1_r[COORD_W-1], x1_r});
  assign negd_c = '0 - diff_c;

  // divider
  logic             div_done;
  logic [MAG_W-1:0] div_q;
  logic [STEP_W-1:0] q_ext;

  pes_div #(
    .N_W(MAG_W),
    .D_W(ROW_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (mag_r),
    .divisor  (span_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign q_ext = {1'b0, div_q};

  logic [CNT_W+INDEX_W-1:0] cnt_wide;
  assign cnt_wide = {{INDEX_W{1'b0}}, cnt_r};

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_scale_r  <= ROW_SCALE_RST;
      edge_limit_r <= EDGE_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_ROW_SCALE:  row_scale_r  <= cfg_wdata[SCALE_W-1:0];
        CFG_EDGE_LIMIT: edge_limit_r <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // path state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r <= '0;
      cur_y_r <= '0;
      sub_x_r <= '0;
      sub_y_r <= '0;
      cnt_r   <= '0;
    end else if (cmd.eval) begin
      cnt_r <= cnt_eff;
      if (limited) begin
        cur_x_r <= cx_eff;
        cur_y_r <= cy_eff;
        sub_x_r <= sx_eff;
        sub_y_r <= sy_eff;
      end else begin
        case (op_r) inside
          OP_MOVE: begin
            sub_x_r <= px_r;
            sub_y_r <= py_r;
            cur_x_r <= px_r;
            cur_y_r <= py_r;
          end
          OP_LINE, OP_CLOSE: begin
            sub_x_r <= sx_eff;
            sub_y_r <= sy_eff;
            cur_x_r <= tx;
            cur_y_r <= ty;
          end
          default: begin
            sub_x_r <= sx_eff;
            sub_y_r <= sy_eff;
            cur_x_r <= cx_eff;
            cur_y_r <= cy_eff;
          end
        endcase
      end
    end else if (cmd.emit) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // payload pipeline
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r <= in_opcode;
      px_r <= in_point_x;
      py_r <= in_point_y;
      ps_r <= in_path_start;
    end
    if (cmd.eval) begin
      x0_r <= cx_eff;
      y0_r <= cy_eff;
      x1_r <= tx;
      y1_r <= ty;
    end
    if (cmd.rows) begin
      r0_r <= to_row(y0_r, row_scale_r);
      r1_r <= to_row(y1_r, row_scale_r);
    end
    if (cmd.order) begin
      top_r  <= top_c;
      bot_r  <= bot_c;
      up_r   <= !down;
      xs_r   <= down ? x0_r : x1_r;
      neg_r  <= diff_c[STEP_W-1];
      mag_r  <= diff_c[STEP_W-1] ? negd_c[MAG_W-1:0] : diff_c[MAG_W-1:0];
      span_r <= bot_c - top_c;
    end
    if (cmd.emit) begin
      top_o_r  <= top_r[OUT_ROW_W-1:0];
      bot_o_r  <= bot_r[OUT_ROW_W-1:0];
      up_o_r   <= up_r;
      xs_o_r   <= xs_r;
      step_o_r <= neg_r ? ('0 - q_ext) : q_ext;
      idx_o_r  <= cnt_wide[INDEX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign stat.edge_go  = !limited && ((op_r == OP_LINE) || (op_r == OP_CLOSE));
  assign stat.flat     = (r0_r == r1_r);
  assign stat.div_done = div_done;
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_row_top    = top_o_r;
  assign out_row_bottom = bot_o_r;
  assign out_winding_up = up_o_r;
  assign out_x_start    = xs_o_r;
  assign out_x_step     = step_o_r;
  assign out_edge_index = idx_o_r;

  // a new transfer is only loaded when the output slot is free
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> stat.out_free)
    else $error("edge loaded over a pending transfer");

  // a load always shows up as a pending transfer
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid)
    else $error("loaded edge not presented");

  // edge counter stays within the capacity
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    LIM_W'(cnt_r) <= cap_ext)
    else $error("edge count past capacity");

  // edge index follows the counter value at the load
  a_index: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_edge_index == $past(cnt_wide[INDEX_W-1:0]))
    else $error("edge index mismatch");

endmodule

`default_nettype wire

>>> hdl/pes_ctrl.sv
// ----------------------------------------------------------------------------
// pes_ctrl
// Controller: sequences capture, evaluation, row mapping, ordering,
// the divide and the output load for one command at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module pes_ctrl
  import pes_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire pes_stat_t stat,
  output pes_cmd_t       cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EVAL   = 3'd1;
  localparam logic [2:0] S_ROWS   = 3'd2;
  localparam logic [2:0] S_ORDER  = 3'd3;
  localparam logic [2:0] S_DSTART = 3'd4;
  localparam logic [2:0] S_DWAIT  = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = stat.edge_go ? S_ROWS : S_IDLE;
      end
      S_ROWS: begin
        cmd.rows  = 1'b1;
        state_nxt = S_ORDER;
      end
      S_ORDER: begin
        cmd.order = 1'b1;
        state_nxt = stat.flat ? S_IDLE : S_DSTART;
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DWAIT;
      end
      S_DWAIT: begin
        if (stat.div_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hdl/path_edge_setup_core.sv
// ----------------------------------------------------------------------------
// path_edge_setup_core
// Edge setup for a scanline rasterizer: turns move, line and close commands
// into ordered edges with winding and a per-sub-scanline x step.
//
//   channel   dir   handshake              payload
//   in_       in    in_valid / in_ready    opcode, point_x, point_y, path_start
//   out_      out   out_valid / out_ready  row_top, row_bottom, winding_up,
//                                          x_start, x_step, edge_index
//   cfg_      in    cfg_we                 cfg_addr, cfg_wdata
//
// one command at a time: move, quad, limited or flat commands return to
// in_ready without the divide; an emitted edge also waits for the 24-step
// serial divider for the x step.
// the finished edge sits in an output register, so the next command is taken
// while it waits; a stalled output holds the controller only at the next load.
// rst_n is synchronous; config resets to row scale 1, edge_limit 2048.
// ----------------------------------------------------------------------------
`default_nettype none

module path_edge_setup_core
  import pes_pkg::*;
#(
  parameter int unsigned EDGE_CAPACITY = EDGE_CAPACITY_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic                      cfg_addr,
  input  wire logic [CFG_W-1:0]          cfg_wdata,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [1:0]                in_opcode,
  input  wire logic signed [COORD_W-1:0] in_point_x,
  input  wire logic signed [COORD_W-1:0] in_point_y,
  input  wire logic                      in_path_start,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic signed [OUT_ROW_W-1:0]    out_row_top,
  output logic signed [OUT_ROW_W-1:0]    out_row_bottom,
  output logic                           out_winding_up,
  output logic signed [COORD_W-1:0]      out_x_start,
  output logic signed [STEP_W-1:0]       out_x_step,
  output logic [INDEX_W-1:0]             out_edge_index
);

  pes_cmd_t  cmd;
  pes_stat_t stat;

  pes_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pes_dp #(
    .EDGE_CAPACITY(EDGE_CAPACITY)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .in_opcode      (in_opcode),
    .in_point_x     (in_point_x),
    .in_point_y     (in_point_y),
    .in_path_start  (in_path_start),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_row_top    (out_row_top),
    .out_row_bottom (out_row_bottom),
    .out_winding_up (out_winding_up),
    .out_x_start    (out_x_start),
    .out_x_step     (out_x_step),
    .out_edge_index (out_edge_index)
  );

endmodule

`default_nettype wire
